// ===== rtl/core/zud_pkg.sv =====
// ----------------------------------------------------------------------------
// zud_pkg
// Shared constants, lookup functions and controller/datapath bundles for the
// reduce-method decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package zud_pkg;

    localparam int WINDOW_SIZE      = 16384;
    localparam int WIN_AW           = 14;
    localparam int FOLLOWER_MAX     = 64;
    localparam int FT_DEPTH         = 256 * FOLLOWER_MAX;
    localparam int FT_AW            = 14;
    localparam int SET_COUNT        = 256;
    localparam int BYTES_PER_RESULT = 8;

    localparam logic [7:0]        ESCAPE_CODE = 8'h90;
    localparam logic [WIN_AW-1:0] CLEAR_LAST  = 14'h3fff;

    // register index decode (paddr[2])
    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef struct packed {
        logic [3:0] need;
        logic       take;
        logic       store_len;
        logic       store_ent;
        logic       dec_set;
        logic       start_dec;
        logic       len_rd;
        logic       len_load;
        logic       tab_rd;
        logic       sym_lit;
        logic       sym_lookup;
        logic       sym_exec;
        logic       hist_rd;
        logic       copy_step;
        logic       flush;
        logic       clr_step;
    } zud_cmd_t;

    typedef struct packed {
        logic [7:0] val;
        logic       bit_last;
        logic       set_zero;
        logic       ent_last;
        logic       bytes_zero;
        logic       sym_put;
        logic       sym_copy;
        logic       copy_end;
        logic       pack_empty;
        logic       pack_full;
        logic       out_free;
        logic       clr_last;
        logic       len_zero;
        logic [3:0] idx_need;
    } zud_stat_t;

    function automatic logic [2:0] clamp_factor(input logic [2:0] f);
        clamp_factor = (f > 3'd4) ? 3'd4 : f;
    endfunction

    function automatic logic [7:0] len_mask(input logic [2:0] f);
        logic [7:0] m;
        unique case (clamp_factor(f))
            3'd1:    m = 8'h7f;
            3'd2:    m = 8'h3f;
            3'd3:    m = 8'h1f;
            3'd4:    m = 8'h0f;
            default: m = 8'h00;
        endcase
        len_mask = m;
    endfunction

    function automatic logic [2:0] dist_shift(input logic [2:0] f);
        logic [2:0] s;
        unique case (clamp_factor(f))
            3'd1:    s = 3'd7;
            3'd2:    s = 3'd6;
            3'd3:    s = 3'd5;
            3'd4:    s = 3'd4;
            default: s = 3'd0;
        endcase
        dist_shift = s;
    endfunction

    function automatic logic [3:0] dist_mask(input logic [2:0] f);
        logic [3:0] m;
        unique case (clamp_factor(f))
            3'd1:    m = 4'h1;
            3'd2:    m = 4'h3;
            3'd3:    m = 4'h7;
            3'd4:    m = 4'hf;
            default: m = 4'h0;
        endcase
        dist_mask = m;
    endfunction

    // smallest b in 1..6 with 2^b >= n
    function automatic logic [3:0] index_width(input logic [5:0] n);
        logic [3:0] b;
        if (n <= 6'd2)       b = 4'd1;
        else if (n <= 6'd4)  b = 4'd2;
        else if (n <= 6'd8)  b = 4'd3;
        else if (n <= 6'd16) b = 4'd4;
        else if (n <= 6'd32) b = 4'd5;
        else                 b = 4'd6;
        index_width = b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zud_ram.sv =====
// ----------------------------------------------------------------------------
// zud_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module zud_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/zud_datapath.sv =====
// ----------------------------------------------------------------------------
// zud_datapath
// Bit gathering, follower and history memories, repeater decode, byte
// packing, output register and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module zud_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire zud_pkg::zud_cmd_t  cmd,
    output zud_pkg::zud_stat_t      stat,
    input  wire logic               stream_bit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             out_bytes,
    output logic [3:0]              byte_count,
    output logic                    final_chunk,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [2:0]  factor_reg;
    logic [31:0] length_reg;

    logic [7:0]  gather_reg,  gather_next;
    logic [3:0]  gcount_reg;
    logic [7:0]  set_reg;
    logic [5:0]  entry_reg;
    logic [5:0]  load_len_reg;
    logic [5:0]  cur_len_reg;
    logic [7:0]  prev_reg;
    logic [7:0]  sym_reg;
    logic [1:0]  rstage_reg;
    logic [7:0]  rheader_reg;
    logic [8:0]  rlen_reg;
    logic [13:0] wp_reg;
    logic [31:0] left_reg;
    logic [13:0] cpos_reg;
    logic [9:0]  cnum_reg;
    logic [63:0] pack_reg;
    logic [3:0]  pcnt_reg;
    logic [13:0] clr_reg;
    logic        ovalid_reg;
    logic [63:0] obytes_reg;
    logic [3:0]  ocount_reg;
    logic        ofinal_reg;

    logic        clearing;
    logic [5:0]  flen_rdata;
    logic [7:0]  ftab_rdata;
    logic [7:0]  hist_rdata;
    logic        fl_we;
    logic [7:0]  fl_waddr;
    logic [5:0]  fl_wdata;
    logic        ft_we;
    logic [13:0] ft_waddr;
    logic [7:0]  ft_wdata;
    logic        hw_we;
    logic [13:0] hw_waddr;
    logic [7:0]  hw_wdata;

    // repeater decode of the current symbol
    logic [7:0]  lmask;
    logic [7:0]  sym_len;
    logic        sym_put;
    logic        sym_copy;
    logic [7:0]  put_val;
    logic [1:0]  stage_next;
    logic [3:0]  dist_hi;
    logic [13:0] copy_dist;
    logic        append;
    logic [7:0]  app_byte;
    logic        cfg_wr;

    assign clearing = cmd.clr_step;
    assign cfg_wr   = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == zud_pkg::REG_LENGTH) ? length_reg : {29'd0, factor_reg};

    assign gather_next = gather_reg | ({7'd0, stream_bit} << gcount_reg[2:0]);

    always_comb
    begin
        lmask      = zud_pkg::len_mask(factor_reg);
        sym_len    = sym_reg & lmask;
        sym_put    = 1'b0;
        sym_copy   = 1'b0;
        put_val    = sym_reg;
        stage_next = 2'd0;
        unique case (rstage_reg)
            2'd0:
            begin
                if (sym_reg == zud_pkg::ESCAPE_CODE)
                begin
                    stage_next = 2'd1;
                end
                else
                begin
                    sym_put = 1'b1;
                end
            end
            2'd1:
            begin
                if (sym_reg == 8'd0)
                begin
                    sym_put = 1'b1;
                    put_val = zud_pkg::ESCAPE_CODE;
                end
                else
                begin
                    stage_next = (sym_len == lmask) ? 2'd2 : 2'd3;
                end
            end
            2'd2:    stage_next = 2'd3;
            default: sym_copy = 1'b1;
        endcase
        dist_hi   = (4'(rheader_reg >> zud_pkg::dist_shift(factor_reg)))
                    & zud_pkg::dist_mask(factor_reg);
        copy_dist = {2'd0, dist_hi, 8'd0} + {6'd0, sym_reg} + 14'd1;
    end

    assign append   = (cmd.sym_exec & sym_put) | cmd.copy_step;
    assign app_byte = cmd.copy_step ? hist_rdata : put_val;

    assign stat.val        = gather_next;
    assign stat.bit_last   = ((gcount_reg + 4'd1) == cmd.need);
    assign stat.set_zero   = (set_reg == 8'd0);
    assign stat.ent_last   = ({1'b0, entry_reg} + 7'd1) >= {1'b0, load_len_reg};
    assign stat.bytes_zero = (left_reg == 32'd0);
    assign stat.sym_put    = sym_put;
    assign stat.sym_copy   = sym_copy;
    assign stat.copy_end   = (cnum_reg == 10'd0) || (left_reg == 32'd0);
    assign stat.pack_empty = (pcnt_reg == 4'd0);
    assign stat.pack_full  = (pcnt_reg == 4'(zud_pkg::BYTES_PER_RESULT));
    assign stat.out_free   = !ovalid_reg || out_ready;
    assign stat.clr_last   = (clr_reg == zud_pkg::CLEAR_LAST);
    assign stat.len_zero   = (flen_rdata == 6'd0);
    assign stat.idx_need   = zud_pkg::index_width(cur_len_reg);

    // memory ports: the clear pass owns every write port
    assign fl_we    = clearing | cmd.store_len;
    assign fl_waddr = clearing ? clr_reg[7:0] : set_reg;
    assign fl_wdata = clearing ? 6'd0 : gather_next[5:0];
    assign ft_we    = clearing | cmd.store_ent;
    assign ft_waddr = clearing ? clr_reg : {set_reg, entry_reg};
    assign ft_wdata = clearing ? 8'd0 : gather_next;
    assign hw_we    = clearing | append;
    assign hw_waddr = clearing ? clr_reg : wp_reg;
    assign hw_wdata = clearing ? 8'd0 : app_byte;

    zud_ram #(.WIDTH(6), .DEPTH(zud_pkg::SET_COUNT)) u_flen (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .raddr (prev_reg),
        .rdata (flen_rdata)
    );

    zud_ram #(.WIDTH(8), .DEPTH(zud_pkg::FT_DEPTH)) u_ftab (
        .clk   (clk),
        .we    (ft_we),
        .waddr (ft_waddr),
        .wdata (ft_wdata),
        .raddr ({prev_reg, gather_next[5:0]}),
        .rdata (ftab_rdata)
    );

    zud_ram #(.WIDTH(8), .DEPTH(zud_pkg::WINDOW_SIZE)) u_hist (
        .clk   (clk),
        .we    (hw_we),
        .waddr (hw_waddr),
        .wdata (hw_wdata),
        .raddr (cpos_reg),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= 3'd1;
            length_reg   <= 32'd0;
            gather_reg   <= 8'd0;
            gcount_reg   <= 4'd0;
            set_reg      <= 8'd255;
            entry_reg    <= 6'd0;
            load_len_reg <= 6'd0;
            cur_len_reg  <= 6'd0;
            prev_reg     <= 8'd0;
            sym_reg      <= 8'd0;
            rstage_reg   <= 2'd0;
            rheader_reg  <= 8'd0;
            rlen_reg     <= 9'd0;
            wp_reg       <= 14'd0;
            left_reg     <= 32'd0;
            cpos_reg     <= 14'd0;
            cnum_reg     <= 10'd0;
            pack_reg     <= 64'd0;
            pcnt_reg     <= 4'd0;
            clr_reg      <= 14'd0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == zud_pkg::REG_FACTOR)
                begin
                    factor_reg <= pwdata[2:0];
                end
                else
                begin
                    length_reg <= pwdata;
                end
            end
            if (clearing)
            begin
                clr_reg <= clr_reg + 14'd1;
            end
            if (cmd.take)
            begin
                if (stat.bit_last)
                begin
                    gather_reg <= 8'd0;
                    gcount_reg <= 4'd0;
                end
                else
                begin
                    gather_reg <= gather_next;
                    gcount_reg <= gcount_reg + 4'd1;
                end
            end
            if (cmd.store_len)
            begin
                load_len_reg <= gather_next[5:0];
                entry_reg    <= 6'd0;
            end
            if (cmd.store_ent)
            begin
                entry_reg <= entry_reg + 6'd1;
            end
            if (cmd.dec_set)
            begin
                set_reg <= set_reg - 8'd1;
            end
            if (cmd.start_dec)
            begin
                left_reg   <= length_reg;
                prev_reg   <= 8'd0;
                rstage_reg <= 2'd0;
            end
            if (cmd.len_load)
            begin
                cur_len_reg <= flen_rdata;
            end
            if (cmd.sym_lit)
            begin
                sym_reg <= gather_next;
            end
            if (cmd.sym_lookup)
            begin
                sym_reg <= ftab_rdata;
            end
            if (cmd.sym_exec)
            begin
                prev_reg   <= sym_reg;
                rstage_reg <= stage_next;
                if ((rstage_reg == 2'd1) && (sym_reg != 8'd0))
                begin
                    rheader_reg <= sym_reg;
                    rlen_reg    <= {1'b0, sym_len};
                end
                if (rstage_reg == 2'd2)
                begin
                    rlen_reg <= rlen_reg + {1'b0, sym_reg};
                end
                if (sym_copy)
                begin
                    cpos_reg <= wp_reg - copy_dist;
                    cnum_reg <= {1'b0, rlen_reg} + 10'd3;
                end
                else
                begin
                    cnum_reg <= 10'd0;
                end
            end
            if (cmd.copy_step)
            begin
                cpos_reg <= cpos_reg + 14'd1;
                cnum_reg <= cnum_reg - 10'd1;
            end
            if (append)
            begin
                wp_reg   <= wp_reg + 14'd1;
                left_reg <= left_reg - 32'd1;
                pack_reg[{pcnt_reg[2:0], 3'b000} +: 8] <= app_byte;
                pcnt_reg <= pcnt_reg + 4'd1;
            end
            if (cmd.flush)
            begin
                pack_reg   <= 64'd0;
                pcnt_reg   <= 4'd0;
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flush)
        begin
            obytes_reg <= pack_reg;
            ocount_reg <= pcnt_reg;
            ofinal_reg <= (left_reg == 32'd0);
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_bytes   = obytes_reg;
    assign byte_count  = ocount_reg;
    assign final_chunk = ofinal_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (ocount_reg != 4'd0) && (ocount_reg <= 4'd8))
        else $error("result beat with bad byte count");
    a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= 4'(zud_pkg::BYTES_PER_RESULT))
        else $error("pack buffer overfilled");
    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        append |-> !stat.pack_full)
        else $error("byte appended to full pack buffer");
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> !stat.pack_empty && stat.out_free)
        else $error("flush of empty buffer or into busy output");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/zud_ctrl.sv =====
// ----------------------------------------------------------------------------
// zud_ctrl
// Decoder sequencer: memory clear, follower set load, symbol decode,
// repeater copy and result flush.
// ----------------------------------------------------------------------------
`default_nettype none

module zud_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire zud_pkg::zud_stat_t stat,
    output zud_pkg::zud_cmd_t       cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_LLEN   = 4'd1;
    localparam logic [3:0] S_LENT   = 4'd2;
    localparam logic [3:0] S_FLAG   = 4'd3;
    localparam logic [3:0] S_LIT    = 4'd4;
    localparam logic [3:0] S_IDX    = 4'd5;
    localparam logic [3:0] S_LOOK   = 4'd6;
    localparam logic [3:0] S_SYM    = 4'd7;
    localparam logic [3:0] S_CPRD   = 4'd8;
    localparam logic [3:0] S_CPWR   = 4'd9;
    localparam logic [3:0] S_FLUSH  = 4'd10;
    localparam logic [3:0] S_RDLEN  = 4'd11;
    localparam logic [3:0] S_GOTLEN = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       take;

    always_comb
    begin
        in_ready = (state_reg == S_LLEN) || (state_reg == S_LENT) ||
                   (state_reg == S_FLAG) || (state_reg == S_LIT)  ||
                   (state_reg == S_IDX)  || (state_reg == S_DONE);
    end

    assign take = in_valid & in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.need   = 4'd8;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_LLEN;
                end
            end
            S_LLEN:
            begin
                cmd.need = 4'd6;
                cmd.take = take;
                if (take && stat.bit_last)
                begin
                    cmd.store_len = 1'b1;
                    if (stat.val[5:0] != 6'd0)
                    begin
                        state_next = S_LENT;
                    end
                    else if (stat.set_zero)
                    begin
                        cmd.start_dec = 1'b1;
                        state_next    = S_RDLEN;
                    end
                    else
                    begin
                        cmd.dec_set = 1'b1;
                    end
                end
            end
            S_LENT:
            begin
                cmd.take = take;
                if (take && stat.bit_last)
                begin
                    cmd.store_ent = 1'b1;
                    if (stat.ent_last)
                    begin
                        if (stat.set_zero)
                        begin
                            cmd.start_dec = 1'b1;
                            state_next    = S_RDLEN;
                        end
                        else
                        begin
                            cmd.dec_set = 1'b1;
                            state_next  = S_LLEN;
                        end
                    end
                end
            end
            S_FLAG:
            begin
                cmd.need = 4'd1;
                cmd.take = take;
                if (take)
                begin
                    state_next = stat.val[0] ? S_LIT : S_IDX;
                end
            end
            S_LIT:
            begin
                cmd.take = take;
                if (take && stat.bit_last)
                begin
                    cmd.sym_lit = 1'b1;
                    state_next  = S_SYM;
                end
            end
            S_IDX:
            begin
                cmd.need = stat.idx_need;
                cmd.take = take;
                if (take && stat.bit_last)
                begin
                    cmd.tab_rd = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.sym_lookup = 1'b1;
                state_next     = S_SYM;
            end
            S_SYM:
            begin
                cmd.sym_exec = 1'b1;
                state_next   = (stat.sym_put || stat.sym_copy) ? S_CPRD : S_RDLEN;
            end
            S_CPRD:
            begin
                if (stat.pack_full)
                begin
                    state_next = S_FLUSH;
                end
                else if (stat.copy_end)
                begin
                    state_next = stat.pack_empty ? S_RDLEN : S_FLUSH;
                end
                else
                begin
                    cmd.hist_rd = 1'b1;
                    state_next  = S_CPWR;
                end
            end
            S_CPWR:
            begin
                cmd.copy_step = 1'b1;
                state_next    = S_CPRD;
            end
            S_FLUSH:
            begin
                // hold until the output register can take the beat
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_CPRD;
                end
            end
            S_RDLEN:
            begin
                if (stat.bytes_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.len_rd = 1'b1;
                    state_next = S_GOTLEN;
                end
            end
            S_GOTLEN:
            begin
                cmd.len_load = 1'b1;
                state_next   = stat.len_zero ? S_LIT : S_FLAG;
            end
            S_DONE:
            begin
                // drop every further bit
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input taken during clear pass");
    a_copy_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_rd |=> cmd.copy_step)
        else $error("history read not followed by copy step");
    a_lookup_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tab_rd |=> cmd.sym_lookup)
        else $error("follower read not followed by lookup");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/zip_unreduce_decoder.sv =====
// ----------------------------------------------------------------------------
// zip_unreduce_decoder
// Bit-serial decompressor for the reduce methods (factor 1..4).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, stream_bit) takes one compressed bit per
//   beat, LSB of each byte first. Output channel (out_valid/out_ready) gives
//   up to eight decoded bytes per beat in out_bytes, first byte in bits 7..0,
//   with byte_count and final_chunk marking the beat that completes
//   output_length. Configure reduce_factor (0x0) and output_length (0x4)
//   over APB before streaming.
//   After reset a clear pass zeroes the follower and history memories;
//   in_ready stays low during it, APB writes are taken.
//   While loading follower sets and gathering symbol bits one bit is taken
//   per cycle; after the last set the first set length is read.
//   A completed symbol then holds in_ready low while it is executed, its
//   bytes are copied and its result beats are flushed, and, unless it ends
//   the output, the next set length is read; a follower index adds a lookup.
//   A result stalled by out_ready holds the decoder in its flush step; one
//   finished result waits in the output register while decoding continues.
//   Once output_length bytes are produced, further bits are accepted and
//   discarded until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module zip_unreduce_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        stream_bit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      out_bytes,
    output logic [3:0]       byte_count,
    output logic             final_chunk,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    zud_pkg::zud_cmd_t  cmd;
    zud_pkg::zud_stat_t stat;

    zud_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    zud_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .stream_bit  (stream_bit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_bytes   (out_bytes),
        .byte_count  (byte_count),
        .final_chunk (final_chunk),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

endmodule

`default_nettype wire

// ===== tb/zud_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zud_scoreboard
// Watches the bit input, the result output and the register port of the
// reduce decompressor, predicts every result beat from the accepted bits
// and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module zud_scoreboard (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        stream_bit,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [63:0] out_bytes,
    input  wire logic [3:0]  byte_count,
    input  wire logic        final_chunk,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               errors,
    output int               pending
);

    typedef enum logic [2:0] {
        ST_LEN, ST_ENT, ST_FLAG, ST_LIT, ST_IDX, ST_DONE
    } dec_state_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } chunk_t;

    localparam logic [8:0] LEN_MASK [0:4] = '{9'h00, 9'h7f, 9'h3f, 9'h1f, 9'h0f};
    localparam int         DIST_SH  [0:4] = '{0, 7, 6, 5, 4};
    localparam logic [3:0] DIST_MSK [0:4] = '{4'h0, 4'h1, 4'h3, 4'h7, 4'hf};

    chunk_t      chunk_q [$];
    logic [7:0]  emitted [$];
    logic        hit_end;

    logic [2:0]  factor;
    logic [31:0] olen;
    dec_state_t  st;
    logic [7:0]  gather;
    int          ngath;
    logic [7:0]  set_idx;
    logic [5:0]  ent;
    logic [5:0]  flen [0:255];
    logic [7:0]  ftab [0:16383];
    logic [7:0]  hist [0:16383];
    logic [13:0] wpos;
    logic [31:0] left;
    logic [7:0]  prev;
    logic [1:0]  rstage;
    logic [7:0]  rhdr;
    logic [8:0]  rlen;

    function automatic int width_of(input int n);
        int b;
        b = 1;
        while (b < 6 && (1 << b) < n)
            b++;
        return b;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic put_byte(input logic [7:0] c);
        if (left == 0)
            return;
        hist[wpos] = c;
        wpos = wpos + 14'd1;
        emitted.push_back(c);
        left = left - 1;
        if (left == 0)
            hit_end = 1'b1;
    endtask

    task automatic next_state();
        if (left == 0)
            st = ST_DONE;
        else if (flen[prev] == 0)
            st = ST_LIT;
        else
            st = ST_FLAG;
    endtask

    task automatic next_set();
        if (set_idx == 0)
        begin
            left   = olen;
            prev   = 8'h00;
            rstage = 2'd0;
            next_state();
        end
        else
        begin
            set_idx = set_idx - 8'd1;
            st = ST_LEN;
        end
    endtask

    task automatic take_symbol(input logic [7:0] ch);
        int          f;
        int          n;
        logic [13:0] pos;
        logic [13:0] copy_dist;
        f = (factor > 3'd4) ? 4 : int'(factor);
        case (rstage)
            2'd0:
                if (ch == zud_pkg::ESCAPE_CODE)
                    rstage = 2'd1;
                else
                    put_byte(ch);
            2'd1:
                if (ch == 8'h00)
                begin
                    put_byte(zud_pkg::ESCAPE_CODE);
                    rstage = 2'd0;
                end
                else
                begin
                    rhdr   = ch;
                    rlen   = {1'b0, ch} & LEN_MASK[f];
                    rstage = (rlen == LEN_MASK[f]) ? 2'd2 : 2'd3;
                end
            2'd2:
            begin
                rlen   = rlen + {1'b0, ch};
                rstage = 2'd3;
            end
            default:
            begin
                copy_dist = {2'b00, 4'((rhdr >> DIST_SH[f]) & DIST_MSK[f]), 8'h00}
                            + {6'd0, ch} + 14'd1;
                pos  = wpos - copy_dist;
                n    = int'(rlen) + 3;
                while (n > 0 && left > 0)
                begin
                    put_byte(hist[pos]);
                    pos = pos + 14'd1;
                    n--;
                end
                rstage = 2'd0;
            end
        endcase
        prev = ch;
        next_state();
    endtask

    task automatic take_bit(input logic b);
        int     need;
        int     v;
        int     nres;
        int     cnt;
        chunk_t c;
        if (st == ST_DONE)
            return;
        case (st)
            ST_LEN:  need = 6;
            ST_FLAG: need = 1;
            ST_IDX:  need = width_of(flen[prev]);
            default: need = 8;
        endcase
        gather[ngath] = b;
        ngath++;
        if (ngath < need)
            return;
        v      = int'(gather) & ((1 << need) - 1);
        gather = 8'h00;
        ngath  = 0;
        case (st)
            ST_LEN:
            begin
                flen[set_idx] = v[5:0];
                if (v > 0)
                begin
                    ent = 6'd0;
                    st  = ST_ENT;
                end
                else
                begin
                    next_set();
                end
            end
            ST_ENT:
            begin
                ftab[{set_idx, ent}] = v[7:0];
                ent = ent + 6'd1;
                if (ent >= flen[set_idx])
                    next_set();
            end
            ST_FLAG: st = (v != 0) ? ST_LIT : ST_IDX;
            ST_LIT:  take_symbol(v[7:0]);
            default: take_symbol(ftab[{prev, v[5:0]}]);
        endcase
        // pack this bit's bytes into beats of up to eight
        nres = (emitted.size() + zud_pkg::BYTES_PER_RESULT - 1) / zud_pkg::BYTES_PER_RESULT;
        for (int k = 0; k < nres; k++)
        begin
            cnt = emitted.size() - k * zud_pkg::BYTES_PER_RESULT;
            if (cnt > zud_pkg::BYTES_PER_RESULT)
                cnt = zud_pkg::BYTES_PER_RESULT;
            c.data = '0;
            for (int j = 0; j < cnt; j++)
                c.data[8*j +: 8] = emitted[k*zud_pkg::BYTES_PER_RESULT + j];
            c.cnt  = cnt[3:0];
            c.last = hit_end && (k == nres - 1);
            chunk_q.push_back(c);
        end
        emitted.delete();
        hit_end = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        chunk_t c;
        if (!rst_n)
        begin
            chunk_q.delete();
            emitted.delete();
            hit_end = 1'b0;
            factor  = 3'd1;
            olen    = '0;
            st      = ST_LEN;
            gather  = '0;
            ngath   = 0;
            set_idx = 8'd255;
            ent     = '0;
            wpos    = '0;
            left    = '0;
            prev    = '0;
            rstage  = '0;
            rhdr    = '0;
            rlen    = '0;
            errors  = 0;
            for (int i = 0; i < 256; i++)
                flen[i] = '0;
            for (int i = 0; i < 16384; i++)
            begin
                ftab[i] = '0;
                hist[i] = '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == zud_pkg::REG_FACTOR)
                    factor = pwdata[2:0];
                else
                    olen = pwdata;
            end
            if (in_valid && in_ready)
                take_bit(stream_bit);
            if (out_valid && out_ready)
            begin
                if (chunk_q.size() == 0)
                begin
                    report("unexpected beat", out_bytes, 64'h0);
                end
                else
                begin
                    c = chunk_q.pop_front();
                    if (out_bytes !== c.data)
                        report("out_bytes", out_bytes, c.data);
                    if (byte_count !== c.cnt)
                        report("byte_count", 64'(byte_count), 64'(c.cnt));
                    if (final_chunk !== c.last)
                        report("final_chunk", 64'(final_chunk), 64'(c.last));
                end
            end
        end
        pending = chunk_q.size();
    end

endmodule

// ===== tb/zip_unreduce_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zip_unreduce_decoder_test
// Loads follower sets and streams encoded symbols (literals, escaped 0x90,
// short and extended copies, out-of-set indexes) through the decompressor
// under several reduce factors and idle patterns; the scoreboard checks.
// ----------------------------------------------------------------------------
module zip_unreduce_decoder_test;

    localparam int LIMIT   = 100000;
    localparam int SETTLE  = 64;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        stream_bit;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        final_chunk;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;

    int          tx_pct;
    int          rx_pct;
    int          hold_req;
    int          hold_seen;
    int          hold_left;
    int          quiet = 0;

    logic [5:0]  tfl [0:255];
    logic [7:0]  tft [0:16383];
    logic [7:0]  tprev;
    logic [2:0]  tfactor;
    int          tally;
    int          olen;

    localparam int LEN_MASK [0:4] = '{0, 'h7f, 'h3f, 'h1f, 'h0f};
    localparam int DIST_SH  [0:4] = '{0, 7, 6, 5, 4};
    localparam int DIST_MSK [0:4] = '{0, 1, 3, 7, 15};

    zip_unreduce_decoder DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .stream_bit(stream_bit),
        .out_valid(out_valid), .out_ready(out_ready), .out_bytes(out_bytes),
        .byte_count(byte_count), .final_chunk(final_chunk),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    zud_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .stream_bit(stream_bit),
        .out_valid(out_valid), .out_ready(out_ready), .out_bytes(out_bytes),
        .byte_count(byte_count), .final_chunk(final_chunk),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // receiver: random stalls plus a single long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable && pready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idx_bits(input int n);
        int b;
        b = 1;
        while (b < 6 && (1 << b) < n)
            b++;
        return b;
    endfunction

    task automatic set_mode(input int m);
        case (m % 4)
            0:
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            1:
            begin
                tx_pct = 59;
                rx_pct = 0;
            end
            2:
            begin
                tx_pct = 0;
                rx_pct = 59;
            end
            default:
            begin
                tx_pct = 6;
                rx_pct = 6;
            end
        endcase
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == zud_pkg::REG_FACTOR)
            tfactor = val[2:0];
    endtask

    task automatic send_bit(input logic b);
        if (tx_pct > 0 && $urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_pct);
        end
        in_valid   <= 1'b1;
        stream_bit <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_bits(input int val, input int n);
        for (int i = 0; i < n; i++)
            send_bit(val[i]);
    endtask

    // how: 0 any coding, 1 flag plus literal, 2 pick from set, 3 index past set
    task automatic send_symbol(input logic [7:0] want, input int how,
                               output logic [7:0] got);
        int n;
        int w;
        int hit;
        int idx;
        n   = tfl[tprev];
        got = want;
        hit = -1;
        if (n == 0)
        begin
            send_bits(want, 8);
        end
        else
        begin
            w = idx_bits(n);
            for (int i = 0; i < n; i++)
                if (hit < 0 && tft[tprev*64 + i] == want)
                    hit = i;
            if (how == 2)
            begin
                hit = $urandom_range(n - 1);
                got = tft[tprev*64 + hit];
            end
            if (how == 3 && (1 << w) > n)
            begin
                idx = $urandom_range((1 << w) - 1, n);
                send_bits(0, 1);
                send_bits(idx, w);
                got = 8'h00;
            end
            else if (how != 1 && hit >= 0 && (how == 2 || $urandom_range(1) == 1))
            begin
                send_bits(0, 1);
                send_bits(hit, w);
            end
            else
            begin
                got = want;
                send_bits(1, 1);
                send_bits(want, 8);
            end
        end
        tprev = got;
    endtask

    task automatic send_copy(input bit big);
        int         f;
        int         mask;
        int         l;
        int         dh;
        bit         ext;
        logic [7:0] v;
        logic [7:0] e;
        logic [7:0] got;
        f    = (tfactor > 3'd4) ? 4 : int'(tfactor);
        mask = LEN_MASK[f];
        dh   = $urandom & DIST_MSK[f];
        if (mask == 0)
        begin
            v   = 8'($urandom_range(255, 1));
            ext = 1'b1;
        end
        else
        begin
            ext = big || ($urandom_range(9) == 0);
            l   = ext ? mask : $urandom_range((mask - 1 < 6) ? mask - 1 : 6);
            v   = 8'((dh << DIST_SH[f]) | l);
            if (v == 8'h00)
                v = 8'h01;
        end
        l = v & mask;
        e = big ? 8'hff : 8'($urandom_range(20));
        send_symbol(zud_pkg::ESCAPE_CODE, 0, got);
        send_symbol(v, 0, got);
        if (ext)
        begin
            send_symbol(e, 0, got);
            l = (mask + e) & 'h1ff;
        end
        send_symbol(8'($urandom), 0, got);
        tally += l + 3;
    endtask

    task automatic send_random_symbol();
        int         r;
        logic [7:0] want;
        logic [7:0] got;
        r = $urandom_range(99);
        if (r < 70)
        begin
            do want = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom);
            while (want == zud_pkg::ESCAPE_CODE);
            r = $urandom_range(9);
            send_symbol(want, (r == 0) ? 3 : (r < 3) ? 2 : 0, got);
            tally++;
        end
        else if (r < 78)
        begin
            send_symbol(zud_pkg::ESCAPE_CODE, 0, got);
            send_symbol(8'h00, 0, got);
            tally++;
        end
        else
        begin
            send_copy(1'b0);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] got;
        int         n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        stream_bit = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_pct     = 0;
        rx_pct     = 0;
        hold_req   = 0;
        tprev      = 8'h00;
        tfactor    = 3'd1;
        tally      = 0;
        olen       = 1500;

        // follower sets: low bytes and the escape always populated, no 0x90 entries
        for (int s = 0; s < 256; s++)
        begin
            n = (s < 16 || s == zud_pkg::ESCAPE_CODE || $urandom_range(9) == 0) ?
                $urandom_range(63, 1) : 0;
            tfl[s] = n[5:0];
        end
        tfl[0] = 6'd2;
        tfl[1] = 6'd63;
        tfl[2] = 6'd1;
        tfl[3] = 6'd32;
        tfl[4] = 6'd33;
        for (int i = 0; i < 16384; i++)
        begin
            do tft[i] = 8'($urandom); while (tft[i] == zud_pkg::ESCAPE_CODE);
            if ((i % 64) >= tfl[i / 64])
                tft[i] = 8'h00;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        reg_write(zud_pkg::REG_LENGTH, 32'hffff_ffff);
        reg_write(zud_pkg::REG_LENGTH, olen);
        reg_write(zud_pkg::REG_FACTOR, 32'd1);

        set_mode(1);
        for (int s = 255; s >= 0; s--)
        begin
            if (s == 128)
                set_mode(2);
            send_bits(tfl[s], 6);
            for (int i = 0; i < tfl[s]; i++)
                send_bits(tft[s*64 + i], 8);
        end

        // directed symbols
        set_mode(0);
        send_symbol(8'h00, 1, got);
        send_symbol(8'h00, 2, got);
        send_symbol(8'hff, 1, got);
        send_symbol(8'h01, 1, got);
        send_symbol(8'h00, 2, got);
        send_symbol(8'h01, 1, got);
        send_symbol(8'h00, 3, got);
        send_symbol(zud_pkg::ESCAPE_CODE, 0, got);
        send_symbol(8'h00, 0, got);
        tally += 8;
        send_copy(1'b0);
        send_copy(1'b1);
        send_symbol(8'h20, 0, got);
        tally++;
        drain();

        // random phases across factors, including out-of-range ones
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:       reg_write(zud_pkg::REG_FACTOR, 32'd2);
                1:       reg_write(zud_pkg::REG_FACTOR, 32'd3);
                2:       reg_write(zud_pkg::REG_FACTOR, 32'd4);
                3:       reg_write(zud_pkg::REG_FACTOR, 32'd0);
                4:       reg_write(zud_pkg::REG_FACTOR, 32'd5);
                5:       reg_write(zud_pkg::REG_FACTOR, 32'd7);
                default: reg_write(zud_pkg::REG_FACTOR, 32'd1);
            endcase
            set_mode(p + 1);
            for (int k = 0; k < 20; k++)
            begin
                if (p == 1 && k == 2)
                    hold_req++;
                send_random_symbol();
            end
            drain();
        end

        // run to the configured length, then feed bits that must be dropped
        reg_write(zud_pkg::REG_FACTOR, 32'd4);
        set_mode(3);
        while (tally < olen)
            send_random_symbol();
        for (int k = 0; k < 20; k++)
            send_bit($urandom_range(1));
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
